### rtl/core/epsm_pkg.sv
// Package for the encoder positioned sweep motor core.
// Holds the command codes, the request and state records and reset constants.
// No dependencies.
package epsm_pkg;

  localparam int unsigned DutyW   = 8;
  localparam int unsigned PosW    = 16;
  localparam int unsigned SlowW   = 15;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [DutyW-1:0]        SLOW_DUTY           = 8'd40;
  localparam logic signed [PosW-1:0]  POS_MAX             = 16'sh7FFF;
  localparam logic signed [PosW-1:0]  POS_MIN             = -16'sh8000;
  localparam logic signed [PosW-1:0]  RETRACT_LIMIT_RESET = 16'sd15;
  localparam logic [SlowW-1:0]        SLOW_COUNT_RESET    = 15'd245;

  typedef enum logic [2:0] {
    CMD_EXTEND  = 3'd0,
    CMD_RETRACT = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_SWITCH  = 3'd3,
    CMD_ENCODER = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RETRACT_LIMIT = 1'b0,
    REG_SLOW_COUNT    = 1'b1
  } cfg_reg_e;

  // One incoming request.
  typedef struct packed {
    logic [2:0]       command;
    logic [DutyW-1:0] duty;
    logic             keep_count;
    logic             clear_count;
    logic             raise_after;
    logic             lower_after;
    logic             switch_level;
    logic             enc_a;
    logic             enc_b;
    logic             not_serving;
  } req_t;

  // Motor and encoder state carried from request to request.
  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [1:0]             prev_phase;
    logic                   extending;
    logic                   stopped;
    logic                   slowed;
    logic                   swept;
    logic                   raise_pend;
    logic                   lower_pend;
    logic [DutyW-1:0]       fwd_duty;
    logic [DutyW-1:0]       bwd_duty;
  } ctrl_t;

  // One result.
  typedef struct packed {
    logic [DutyW-1:0]       forward_duty;
    logic [DutyW-1:0]       backward_duty;
    logic                   raise_request;
    logic                   lower_request;
    logic                   swept_flag;
    logic signed [PosW-1:0] position;
  } res_t;

  localparam ctrl_t CTRL_RESET = '{
    position:   '0,
    prev_phase: 2'b00,
    extending:  1'b0,
    stopped:    1'b1,
    slowed:     1'b0,
    swept:      1'b0,
    raise_pend: 1'b0,
    lower_pend: 1'b0,
    fwd_duty:   '0,
    bwd_duty:   '0
  };

endpackage

### rtl/core/encoder_positioned_sweep_motor_core.sv
// Top level of the encoder positioned sweep motor core.
// Uses epsm_pkg and instantiates epsm_step.
//
// Usage: each request on the slave stream carries one command in tuser
// (extend, retract, stop, end switch event, encoder sample) and its operands
// in tdata. Every accepted request yields exactly one result on the master
// stream: both drive duties, the raise and lower request pulses, the swept
// flag and the saturated position count.
// Two thresholds are written through the plain write port while the core is
// idle: index 0 is the signed retract limit, index 1 the slow count.
// An accepted request is held in the input register; the decode and state
// update then land their outcome in the result register. Throughput is one
// request per cycle while the result side keeps taking results. The output
// register decouples the two sides: when the receiver stalls, the core still
// takes one more request into its input register and only then drops
// s_axis_tready.
// Reset puts the motor in the stopped state with zero duties, a zero count,
// no pending platform requests and the thresholds at 15 and 245; both
// pipeline stages are emptied.
module encoder_positioned_sweep_motor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0: duty[7:0], keep_count, clear_count, raise_after,
  // lower_after, switch_level, enc_a, enc_b, not_serving.
  input  logic [15:0] s_axis_tdata,
  // tuser: command[2:0].
  input  logic [2:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, from bit 0: forward_duty[7:0], backward_duty[7:0], raise_request,
  // lower_request, swept_flag, position[15:0], then five zero bits.
  output logic [39:0] m_axis_tdata,
  // Threshold write port.
  input  logic                         cfg_we_i,
  input  logic [epsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                  cfg_data_i
);
  import epsm_pkg::*;

  logic                   in_vld_q;
  logic                   in_vld_d;
  req_t                   in_q;
  logic                   out_vld_q;
  logic                   out_vld_d;
  res_t                   res_q;
  res_t                   res_d;
  ctrl_t                  st_q;
  ctrl_t                  st_d;
  logic signed [PosW-1:0] retract_limit_q;
  logic [SlowW-1:0]       slow_count_q;
  logic                   in_take;
  logic                   advance;
  req_t                   req_in;

  assign req_in = '{
    command:      s_axis_tuser,
    duty:         s_axis_tdata[7:0],
    keep_count:   s_axis_tdata[8],
    clear_count:  s_axis_tdata[9],
    raise_after:  s_axis_tdata[10],
    lower_after:  s_axis_tdata[11],
    switch_level: s_axis_tdata[12],
    enc_a:        s_axis_tdata[13],
    enc_b:        s_axis_tdata[14],
    not_serving:  s_axis_tdata[15]
  };

  // A buffered request moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  epsm_step u_step (
    .req_i           (in_q),
    .cur_i           (st_q),
    .retract_limit_i (retract_limit_q),
    .slow_count_i    (slow_count_q),
    .nxt_o           (st_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= CTRL_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retract_limit_q <= RETRACT_LIMIT_RESET;
      slow_count_q    <= SLOW_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RETRACT_LIMIT: retract_limit_q <= $signed(cfg_data_i);
        REG_SLOW_COUNT:    slow_count_q    <= cfg_data_i[SlowW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= req_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, res_q.position, res_q.swept_flag,
                          res_q.lower_request, res_q.raise_request,
                          res_q.backward_duty, res_q.forward_duty};

`ifndef SYNTHESIS
  // The motor is never marked as both stopped and extending.
  a_stop_ext_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.stopped && st_q.extending))
    else $error("stopped and extending marks both set");

  // A platform request pulse only comes with a stop, so both duties are zero.
  a_pulse_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.raise_request || res_q.lower_request)) |->
      (res_q.forward_duty == '0) && (res_q.backward_duty == '0))
    else $error("request pulse without a stopped motor");

  // Reaching the retract limit stops the motor.
  a_swept_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q.swept) |-> st_q.stopped && (st_q.fwd_duty == '0) &&
      (st_q.bwd_duty == '0))
    else $error("swept set while the motor still drives");

  // The request side only stalls when both stages hold data and the
  // receiver is not taking the result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("request side stalled with room in the pipeline");
`endif

endmodule

### rtl/core/epsm_step.sv
// Next-state and result logic for one request of the sweep motor core.
// Purely combinational; uses epsm_pkg.
module epsm_step (
  input  epsm_pkg::req_t                     req_i,
  input  epsm_pkg::ctrl_t                    cur_i,
  input  logic signed [epsm_pkg::PosW-1:0]   retract_limit_i,
  input  logic [epsm_pkg::SlowW-1:0]         slow_count_i,
  output epsm_pkg::ctrl_t                    nxt_o,
  output epsm_pkg::res_t                     res_o
);
  import epsm_pkg::*;

  logic [1:0]             phase;
  logic [3:0]             pair;
  logic                   step_up;
  logic                   step_dn;
  logic signed [PosW-1:0] pos_enc;
  logic signed [PosW-1:0] slow_s;
  logic                   ext_req;
  logic [DutyW-1:0]       ext_duty;
  logic                   ext_keep;
  logic                   slow_set;
  logic                   stop_req;
  logic                   pulse_raise;
  logic                   pulse_lower;
  ctrl_t                  nxt;

  // Quadrature decode: pair is the new phase above the previous phase.
  assign phase   = {req_i.enc_a, req_i.enc_b};
  assign pair    = {phase, cur_i.prev_phase};
  assign step_up = (pair == 4'b0001) || (pair == 4'b1000) ||
                   (pair == 4'b0111) || (pair == 4'b1110);
  assign step_dn = (pair == 4'b0010) || (pair == 4'b0100) ||
                   (pair == 4'b1011) || (pair == 4'b1101);
  assign slow_s  = $signed({1'b0, slow_count_i});

  always_comb begin
    pos_enc = cur_i.position;
    if (step_up && (cur_i.position != POS_MAX)) begin
      pos_enc = cur_i.position + 16'sd1;
    end else if (step_dn && (cur_i.position != POS_MIN)) begin
      pos_enc = cur_i.position - 16'sd1;
    end
  end

  always_comb begin
    nxt         = cur_i;
    ext_req     = 1'b0;
    ext_duty    = req_i.duty;
    ext_keep    = req_i.keep_count;
    slow_set    = 1'b0;
    stop_req    = 1'b0;
    pulse_raise = 1'b0;
    pulse_lower = 1'b0;

    unique case (req_i.command)
      CMD_EXTEND: begin
        ext_req = 1'b1;
      end
      CMD_RETRACT: begin
        nxt.swept      = 1'b0;
        nxt.raise_pend = req_i.raise_after;
        nxt.lower_pend = req_i.lower_after;
        if (req_i.clear_count) begin
          nxt.position = '0;
        end
        nxt.stopped  = 1'b0;
        nxt.fwd_duty = '0;
        nxt.bwd_duty = req_i.duty;
      end
      CMD_STOP: begin
        stop_req = 1'b1;
      end
      CMD_SWITCH: begin
        stop_req = cur_i.extending;
      end
      CMD_ENCODER: begin
        nxt.prev_phase = phase;
        nxt.position   = pos_enc;
        if (!cur_i.extending && !cur_i.stopped) begin
          if (pos_enc <= retract_limit_i) begin
            stop_req  = 1'b1;
            nxt.swept = 1'b1;
          end
        end else if (cur_i.extending && !cur_i.slowed && req_i.not_serving &&
                     (pos_enc >= slow_s)) begin
          ext_req  = 1'b1;
          ext_duty = SLOW_DUTY;
          ext_keep = 1'b0;
          slow_set = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Extend only acts while the end switch is high.
    if (ext_req && req_i.switch_level) begin
      if (!ext_keep) begin
        nxt.position = '0;
      end
      nxt.extending = 1'b1;
      nxt.slowed    = 1'b0;
      nxt.stopped   = 1'b0;
      nxt.fwd_duty  = ext_duty;
      nxt.bwd_duty  = '0;
    end
    if (slow_set) begin
      nxt.slowed = 1'b1;
    end

    // A stop issues the pending platform requests.
    if (stop_req) begin
      nxt.fwd_duty   = '0;
      nxt.bwd_duty   = '0;
      nxt.stopped    = 1'b1;
      nxt.extending  = 1'b0;
      pulse_raise    = cur_i.raise_pend;
      pulse_lower    = cur_i.lower_pend;
      nxt.raise_pend = 1'b0;
      nxt.lower_pend = 1'b0;
    end
  end

  assign nxt_o = nxt;

  assign res_o.forward_duty  = nxt.fwd_duty;
  assign res_o.backward_duty = nxt.bwd_duty;
  assign res_o.raise_request = pulse_raise;
  assign res_o.lower_request = pulse_lower;
  assign res_o.swept_flag    = nxt.swept;
  assign res_o.position      = nxt.position;

endmodule

### tb/epsm_checker.sv
`timescale 1ns / 1ps
// Result checker for the encoder positioned sweep motor core.
// Watches the request, result and threshold ports, predicts every result and compares it.
// Depends on epsm_pkg for the command codes, register indexes, widths and the result record.
module epsm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic [15:0]                 req_data_i,
  input  logic [2:0]                  req_cmd_i,
  input  logic                        res_valid_i,
  input  logic                        res_ready_i,
  input  logic [39:0]                 res_data_i,
  input  logic                        cfg_we_i,
  input  logic [epsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  output int                          errors_o,
  output int                          pending_o
);
  import epsm_pkg::*;

  localparam int unsigned KeepBit    = 8;
  localparam int unsigned ClearBit   = 9;
  localparam int unsigned RaiseBit   = 10;
  localparam int unsigned LowerBit   = 11;
  localparam int unsigned LevelBit   = 12;
  localparam int unsigned EncABit    = 13;
  localparam int unsigned EncBBit    = 14;
  localparam int unsigned NotServBit = 15;
  localparam int unsigned ShownMax   = 10;

  logic signed [PosW-1:0] limit_q;
  logic [SlowW-1:0]       slow_q;
  logic signed [PosW-1:0] count_q;
  logic [1:0]             phase_q;
  logic                   extending_q;
  logic                   stopped_q;
  logic                   slowed_q;
  logic                   swept_q;
  logic                   raise_pend_q;
  logic                   lower_pend_q;
  logic [DutyW-1:0]       fwd_q;
  logic [DutyW-1:0]       bwd_q;
  res_t                   expected_q[$];
  int                     errors;

  function automatic void drive_forward(input logic [DutyW-1:0] duty, input logic keep,
                                        input logic level);
    if (level) begin
      if (!keep) count_q = '0;
      extending_q = 1'b1;
      slowed_q    = 1'b0;
      stopped_q   = 1'b0;
      fwd_q       = duty;
      bwd_q       = '0;
    end
  endfunction

  // Stopping releases whatever platform requests the last retract left behind.
  function automatic void halt(inout res_t r);
    fwd_q       = '0;
    bwd_q       = '0;
    stopped_q   = 1'b1;
    extending_q = 1'b0;
    if (raise_pend_q) begin
      r.raise_request = 1'b1;
      raise_pend_q    = 1'b0;
    end
    if (lower_pend_q) begin
      r.lower_request = 1'b1;
      lower_pend_q    = 1'b0;
    end
  endfunction

  function automatic res_t motor_step(input logic [2:0] cmd, input logic [15:0] d);
    res_t                 r;
    logic [1:0]           phase;
    logic signed [PosW:0] wide;
    r = '0;
    case (cmd)
      CMD_EXTEND: drive_forward(d[DutyW-1:0], d[KeepBit], d[LevelBit]);
      CMD_RETRACT: begin
        swept_q      = 1'b0;
        raise_pend_q = d[RaiseBit];
        lower_pend_q = d[LowerBit];
        if (d[ClearBit]) count_q = '0;
        stopped_q = 1'b0;
        fwd_q     = '0;
        bwd_q     = d[DutyW-1:0];
      end
      CMD_STOP:   halt(r);
      CMD_SWITCH: if (extending_q) halt(r);
      CMD_ENCODER: begin
        phase = {d[EncABit], d[EncBBit]};
        // New phase in the upper two bits, old phase below.
        case ({phase, phase_q})
          4'b0001, 4'b1000, 4'b0111, 4'b1110: if (count_q != POS_MAX) count_q = count_q + 16'sd1;
          4'b0010, 4'b0100, 4'b1011, 4'b1101: if (count_q != POS_MIN) count_q = count_q - 16'sd1;
          default: ;
        endcase
        phase_q = phase;
        wide    = {count_q[PosW-1], count_q};
        if (!extending_q && !stopped_q) begin
          if (count_q <= limit_q) begin
            halt(r);
            swept_q = 1'b1;
          end
        end else if (extending_q && !slowed_q && d[NotServBit] &&
                     wide >= $signed({2'b00, slow_q})) begin
          drive_forward(SLOW_DUTY, 1'b0, d[LevelBit]);
          slowed_q = 1'b1;
        end
      end
      default: ;
    endcase
    r.forward_duty  = fwd_q;
    r.backward_duty = bwd_q;
    r.swept_flag    = swept_q;
    r.position      = count_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    if (!rst_ni) begin
      limit_q      = RETRACT_LIMIT_RESET;
      slow_q       = SLOW_COUNT_RESET;
      count_q      = '0;
      phase_q      = 2'b00;
      extending_q  = 1'b0;
      stopped_q    = 1'b1;
      slowed_q     = 1'b0;
      swept_q      = 1'b0;
      raise_pend_q = 1'b0;
      lower_pend_q = 1'b0;
      fwd_q        = '0;
      bwd_q        = '0;
      errors       = 0;
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RETRACT_LIMIT) limit_q = cfg_data_i;
        else slow_q = cfg_data_i[SlowW-1:0];
      end
      if (res_valid_i && res_ready_i) begin
        got               = '0;
        got.forward_duty  = res_data_i[7:0];
        got.backward_duty = res_data_i[15:8];
        got.raise_request = res_data_i[16];
        got.lower_request = res_data_i[17];
        got.swept_flag    = res_data_i[18];
        got.position      = res_data_i[34:19];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= ShownMax)
            $display("%0t: result with nothing expected: fwd=%0d bwd=%0d pos=%0d", $realtime,
                     got.forward_duty, got.backward_duty, got.position);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= ShownMax) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected fwd=%0d bwd=%0d raise=%0b lower=%0b swept=%0b pos=%0d",
                       want.forward_duty, want.backward_duty, want.raise_request,
                       want.lower_request, want.swept_flag, want.position);
              $display("  got      fwd=%0d bwd=%0d raise=%0b lower=%0b swept=%0b pos=%0d",
                       got.forward_duty, got.backward_duty, got.raise_request,
                       got.lower_request, got.swept_flag, got.position);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(motor_step(req_cmd_i, req_data_i));
      errors_o  <= errors;
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for encoder_positioned_sweep_motor_core: clock, reset, requests,
// result-side stalls, threshold writes and the verdict.
// Depends on epsm_pkg and on epsm_checker, which predicts and compares every result.
module tb;
  import epsm_pkg::*;

  // Chance in percent that either side idles in a given cycle.
  localparam int unsigned StallPct   = 26;
  // Cycles without any handshake or register write before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;
  // Random requests per threshold setting.
  localparam int unsigned PhaseItems = 260;
  localparam int unsigned PhaseCount = 5;

  // Operand positions inside the request tdata.
  localparam int unsigned KeepBit    = 8;
  localparam int unsigned ClearBit   = 9;
  localparam int unsigned RaiseBit   = 10;
  localparam int unsigned LowerBit   = 11;
  localparam int unsigned LevelBit   = 12;
  localparam int unsigned EncABit    = 13;
  localparam int unsigned EncBBit    = 14;
  localparam int unsigned NotServBit = 15;

  // How an encoder sample moves the phase relative to the last one sent.
  typedef enum int {STEP_UP, STEP_DOWN, STEP_HOLD, STEP_SKIP, STEP_ANY} enc_step_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;
  logic [2:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [15:0]        cfg_data_i    = '0;

  int          mismatches;
  int          in_flight;
  // While set, neither side idles.
  bit          calm         = 1'b0;
  // Last encoder phase sent, so that well-formed quadrature sequences can be built.
  logic [1:0]  enc_phase    = 2'b00;
  int unsigned sent         = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  encoder_positioned_sweep_motor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  epsm_checker motor_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_cmd_i   (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (mismatches),
    .pending_o   (in_flight)
  );

  // The receiver stalls at random unless a calm stretch is running.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= StallPct);
  end

  // Watchdog: any request, result or register write shows the core is alive.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, after a random idle gap, and returns at the edge that accepts it.
  // tvalid stays high into the next request unless that one starts with a gap.
  task automatic send_req(input logic [2:0] cmd, input logic [15:0] data);
    while (!calm && $urandom_range(0, 99) < StallPct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // A request whose operands are all random. Random encoder samples move the tracked phase.
  task automatic plain(input logic [2:0] cmd);
    logic [15:0] d;
    d = 16'($urandom);
    if (cmd == CMD_ENCODER) enc_phase = {d[EncABit], d[EncBBit]};
    send_req(cmd, d);
  endtask

  task automatic extend(input logic [7:0] duty, input logic keep, input logic level);
    logic [15:0] d;
    d           = 16'($urandom);
    d[7:0]      = duty;
    d[KeepBit]  = keep;
    d[LevelBit] = level;
    send_req(CMD_EXTEND, d);
  endtask

  task automatic retract(input logic [7:0] duty, input logic clear, input logic raise_req,
                         input logic lower_req);
    logic [15:0] d;
    d           = 16'($urandom);
    d[7:0]      = duty;
    d[ClearBit] = clear;
    d[RaiseBit] = raise_req;
    d[LowerBit] = lower_req;
    send_req(CMD_RETRACT, d);
  endtask

  // Quadrature order for counting up is 01, 00, 10, 11; counting down runs the other way.
  // A skip jumps two phases at once, which the core must treat as no movement.
  task automatic encoder_sample(input enc_step_e step, input logic level,
                                input logic not_serving);
    logic [15:0] d;
    logic [1:0]  nxt;
    case (step)
      STEP_UP: begin
        case (enc_phase)
          2'b01:   nxt = 2'b00;
          2'b00:   nxt = 2'b10;
          2'b10:   nxt = 2'b11;
          default: nxt = 2'b01;
        endcase
      end
      STEP_DOWN: begin
        case (enc_phase)
          2'b00:   nxt = 2'b01;
          2'b01:   nxt = 2'b11;
          2'b11:   nxt = 2'b10;
          default: nxt = 2'b00;
        endcase
      end
      STEP_HOLD: nxt = enc_phase;
      STEP_SKIP: nxt = ~enc_phase;
      default:   nxt = 2'($urandom);
    endcase
    enc_phase     = nxt;
    d             = 16'($urandom);
    d[EncABit]    = nxt[1];
    d[EncBBit]    = nxt[0];
    d[LevelBit]   = level;
    d[NotServBit] = not_serving;
    send_req(CMD_ENCODER, d);
  endtask

  // Mostly the intended direction, now and then a reversal or a broken transition.
  function automatic enc_step_e pick_step(input enc_step_e main);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return main;
    if (roll < 88) return (main == STEP_UP) ? STEP_DOWN : STEP_UP;
    if (roll < 92) return STEP_HOLD;
    if (roll < 96) return STEP_SKIP;
    return STEP_ANY;
  endfunction

  // Holds the sender back until every result has come, then lets the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the retract limit, then the slow count; only called while the core is idle.
  task automatic set_thresholds(input logic signed [15:0] limit, input logic [14:0] slow);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RETRACT_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SLOW_COUNT;
    cfg_data_i <= {1'b0, slow};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One random motion: a retract sweep toward the limit, an extend run toward the slow point,
  // or a burst of unstructured requests including the unused command codes.
  task automatic run_scenario();
    int unsigned kind;
    int unsigned steps;
    kind  = $urandom_range(0, 99);
    steps = $urandom_range(2, 40);
    if (kind < 40) begin
      retract(8'($urandom), $urandom_range(0, 3) != 0, 1'($urandom), 1'($urandom));
      repeat (steps) encoder_sample(pick_step(STEP_DOWN), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 1) != 0) plain(CMD_STOP);
    end else if (kind < 80) begin
      extend(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0);
      repeat (steps) encoder_sample(pick_step(STEP_UP), $urandom_range(0, 7) != 0,
                                    $urandom_range(0, 4) != 0);
      // Leaving the motor running lets the next retract start while still extending.
      case ($urandom_range(0, 3))
        0:       plain(CMD_STOP);
        1, 2:    plain(CMD_SWITCH);
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) plain(3'($urandom));
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with tight thresholds so every limit is reached in a few steps.
    set_thresholds(-16'sd2, 15'd3);
    // Codes beyond the encoder sample mean nothing and must leave the state alone.
    for (int c = CMD_ENCODER + 1; c < 8; c++) plain(3'(c));
    // End switch event with the motor stopped is ignored.
    plain(CMD_SWITCH);
    // Extend with the switch low is ignored; with it high the count is cleared.
    extend(8'hFF, 1'b0, 1'b0);
    extend(8'hFF, 1'b0, 1'b1);
    // Climb to the slow point with the switch low there: marked slowed, duty unchanged.
    encoder_sample(STEP_UP, 1'b1, 1'b1);
    encoder_sample(STEP_UP, 1'b1, 1'b1);
    encoder_sample(STEP_UP, 1'b0, 1'b1);
    // Repeated phase and a double step leave the count alone.
    encoder_sample(STEP_HOLD, 1'b1, 1'b1);
    encoder_sample(STEP_SKIP, 1'b1, 1'b1);
    // Retract while extending keeps the extending mark, so no limit check follows.
    retract(8'd200, 1'b0, 1'b1, 1'b1);
    encoder_sample(STEP_DOWN, 1'b1, 1'b1);
    // The switch event stops the motor and releases both platform requests.
    plain(CMD_SWITCH);
    // A real retraction down to the limit stops and marks the sweep done.
    retract(8'd1, 1'b1, 1'b1, 1'b0);
    repeat (3) encoder_sample(STEP_DOWN, 1'b1, 1'b0);
    plain(CMD_STOP);
    // A serving-area sample short of the slow point changes nothing; reaching it outside the serving area re-extends.
    extend(8'h80, 1'b0, 1'b1);
    encoder_sample(STEP_UP, 1'b1, 1'b0);
    repeat (2) encoder_sample(STEP_UP, 1'b1, 1'b1);
    plain(CMD_STOP);
    extend(8'h00, 1'b1, 1'b1);
    plain(CMD_STOP);
    drain();

    // Random phases, first at the threshold extremes, then at small random settings.
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p)
        0:       set_thresholds(POS_MAX, 15'd0);
        1:       set_thresholds(POS_MIN, 15'h7FFF);
        default: set_thresholds(16'($signed($urandom_range(0, 30)) - 20),
                                15'($urandom_range(0, 30)));
      endcase
      // One whole phase runs without any idling on either side.
      calm <= (p == 2);
      goal = sent + PhaseItems;
      while (sent < goal) begin
        if ($urandom_range(0, 99) == 0) drain();
        run_scenario();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/epsm_pkg.sv
rtl/core/epsm_step.sv
rtl/core/encoder_positioned_sweep_motor_core.sv
tb/epsm_checker.sv
tb/tb.sv
